/* src/tkins_pkg.sv */
// Types, codes and sizes shared by the top-k sorted insert unit and its cells
`timescale 1ns / 1ps

package tkins_pkg;

    // number of kept entries
    localparam int LIST_SIZE = 16;

    // field widths fixed by the item formats
    localparam int DIST_W  = 32;
    localparam int ID_W    = 31;
    localparam int FLOOR_W = 4;
    localparam int SLOT_W  = 5;

    // operation codes
    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_READOUT = 1'b1
    } t_opcode;

    // control state of the top level
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // input item
    typedef struct packed {
        t_opcode             opcode;
        logic [DIST_W-1:0]   distance;
        logic [ID_W-1:0]     item_id;
        logic [FLOOR_W-1:0]  floor_position;
    } t_in_item;

    // result item
    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   slot;
        logic [DIST_W-1:0]   entry_distance;
        logic [ID_W-1:0]     entry_id;
        logic                last;
    } t_out_item;

    // one kept entry
    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [ID_W-1:0]     id;
    } t_entry;

    // value of an empty entry
    localparam t_entry ENTRY_CLEAR = '{distance: '1, id: '0};

    // per-cycle command to every cell
    typedef struct packed {
        logic ins_en;
        logic read_shift;
    } t_cell_ctl;

endpackage

/* src/tkins_cell.sv */
// One slot of the sorted list: compare, hold, take the candidate or shift
`timescale 1ns / 1ps

module tkins_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tkins_pkg::t_cell_ctl i_ctl,
    input  tkins_pkg::t_entry  i_cand,
    input  logic               i_floor_ok,
    input  logic               i_g_next,
    input  logic               i_le_prev,
    input  tkins_pkg::t_entry  i_prev,
    input  tkins_pkg::t_entry  i_next,
    output tkins_pkg::t_entry  o_ent,
    output logic               o_g,
    output logic               o_le
);
    import tkins_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   w_lt;
    logic   w_take;
    logic   w_shift;

    // smaller entry here or in any later slot decides the insert point
    always_comb begin
        w_lt    = i_floor_ok && (r_ent.distance < i_cand.distance);
        o_g     = w_lt || i_g_next;
        o_le    = i_floor_ok && !o_g;
        w_take  = o_le && !i_le_prev;
        w_shift = o_le && i_le_prev;
    end

    // next entry: readout pulls from the next slot, insert takes or shifts
    always_comb begin
        n_ent = r_ent;
        if (i_ctl.read_shift) begin
            n_ent = i_next;
        end else if (i_ctl.ins_en) begin
            if (w_take) begin
                n_ent = i_cand;
            end else if (w_shift) begin
                n_ent = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= ENTRY_CLEAR;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_ent = r_ent;

endmodule

/* src/top_k_sorted_insert_unit.sv */
// Top level: chain of list cells, readout sequencer and output register
`timescale 1ns / 1ps
//
// channel   direction  valid     stall     payload
// input     in         i_valid   o_stall   i_item  (t_in_item)
// result    out        o_valid   i_stall   o_result (t_out_item)
//
// An insert is accepted in the cycle the output register is free, and its result
// shows the next cycle; inserts can follow every cycle.
// During a readout the list shifts one slot toward slot 0 per result emitted,
// refilling with empty entries.
// Synchronous reset empties the list and the output register.
// A stall on the result side holds the result and stalls the input side.

module top_k_sorted_insert_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  tkins_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tkins_pkg::t_out_item o_result
);
    import tkins_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [SLOT_W-1:0]  r_cnt;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_out_free;
    logic               w_emit;
    logic               w_in_acc;
    logic               w_ins;
    logic               w_rd_start;
    logic               w_rd_last;
    t_cell_ctl          w_ctl;
    t_entry             w_cand;
    t_entry             w_ent    [LIST_SIZE];
    logic [LIST_SIZE:0] w_g;
    logic [LIST_SIZE-1:0] w_le;
    logic [LIST_SIZE-1:0] w_floor_ok;
    logic [LIST_SIZE-1:0] w_take;
    logic [SLOT_W-1:0]  w_pos;
    logic               w_accept;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_rd_last  = (r_cnt == SLOT_W'(LIST_SIZE - 1));

    // fsm outputs
    always_comb begin
        o_stall = 1'b1;
        w_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = !w_out_free;
            end
            ST_READ: begin
                o_stall = 1'b1;
                w_emit  = w_out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign w_in_acc   = i_valid && !o_stall;
    assign w_ins      = w_in_acc && (i_item.opcode == OP_INSERT);
    assign w_rd_start = w_in_acc && (i_item.opcode == OP_READOUT);

    // fsm next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_rd_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (w_emit && w_rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_rd_start) begin
                r_cnt <= '0;
            end else if (w_emit) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // cell commands and candidate
    always_comb begin
        w_ctl.ins_en     = w_ins;
        w_ctl.read_shift = w_emit;
        w_cand.distance  = i_item.distance;
        w_cand.id        = i_item.item_id;
    end

    assign w_g[LIST_SIZE] = 1'b0;

    // row of cells, slot 0 holds the best entry
    for (genvar j = 0; j < LIST_SIZE; j++) begin : g_cell
        logic   w_le_prev;
        t_entry w_prev;
        t_entry w_next;

        assign w_floor_ok[j] = (32'(i_item.floor_position) <= 32'(j));

        if (j == 0) begin : g_first
            assign w_le_prev = 1'b0;
            assign w_prev    = ENTRY_CLEAR;
        end else begin : g_mid
            assign w_le_prev = w_le[j-1];
            assign w_prev    = w_ent[j-1];
        end

        if (j == LIST_SIZE - 1) begin : g_tail
            assign w_next = ENTRY_CLEAR;
        end else begin : g_body
            assign w_next = w_ent[j+1];
        end

        assign w_take[j] = w_le[j] && !w_le_prev;

        tkins_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_cand     (w_cand),
            .i_floor_ok (w_floor_ok[j]),
            .i_g_next   (w_g[j+1]),
            .i_le_prev  (w_le_prev),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .o_ent      (w_ent[j]),
            .o_g        (w_g[j]),
            .o_le       (w_le[j])
        );
    end

    // insert slot from the one-hot take vector
    always_comb begin
        w_pos = '0;
        for (int j = 0; j < LIST_SIZE; j++) begin
            if (w_take[j]) begin
                w_pos = w_pos | SLOT_W'(j);
            end
        end
        w_accept = w_le[LIST_SIZE-1];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ins || w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_out.accepted <= w_accept;
            r_out.last     <= 1'b1;
            if (w_accept) begin
                r_out.slot           <= w_pos;
                r_out.entry_distance <= w_ent[LIST_SIZE-1].distance;
                r_out.entry_id       <= w_ent[LIST_SIZE-1].id;
            end else begin
                r_out.slot           <= SLOT_W'(LIST_SIZE);
                r_out.entry_distance <= i_item.distance;
                r_out.entry_id       <= i_item.item_id;
            end
        end else if (w_emit) begin
            r_out.accepted       <= 1'b1;
            r_out.slot           <= r_cnt;
            r_out.entry_distance <= w_ent[0].distance;
            r_out.entry_id       <= w_ent[0].id;
            r_out.last           <= w_rd_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // at most one cell takes the candidate
    a_take_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_take))
        else $error("more than one cell takes the candidate");

    // an accepted insert has exactly one taking cell
    a_take_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> $onehot(w_take))
        else $error("accepted insert without a unique slot");

    // the last readout result returns the sequencer to idle
    a_read_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && w_emit && w_rd_last) |=> (r_state == ST_IDLE))
        else $error("readout did not finish");

    // a rejected insert reports the out-of-list slot
    a_reject_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ins && !w_accept) |=> (r_out.slot == SLOT_W'(LIST_SIZE) && !r_out.accepted))
        else $error("rejected insert with wrong slot");

    // readout results carry their rank
    a_read_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out.slot == $past(r_cnt) && r_out.accepted))
        else $error("readout rank mismatch");
`endif

endmodule

/* test/tb.sv */
// Self-checking bench for the top-k sorted insert unit: shadow list, queued items, random idling
`timescale 1ns / 1ps

module tb;
    import tkins_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_ITEMS  = 210;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 40;

    // receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    // distance flavors for random episodes
    localparam int DIST_FULL  = 0;
    localparam int DIST_TIES  = 1;
    localparam int DIST_FLOAT = 2;
    localparam int DIST_EDGES = 3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_result;

    // items waiting to be sent; drain marks an item sent only once nothing is owed
    t_in_item  pending_items[$];
    bit        pending_drain[$];

    // shadow copy of the kept list and the results it still owes
    logic [DIST_W-1:0] shadow_dist [LIST_SIZE];
    logic [ID_W-1:0]   shadow_id   [LIST_SIZE];
    t_out_item         owed_results[$];
    int                results_owed   = 0;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    int burst_left  = 1;
    int gap_left    = 0;
    int stall_mode  = STALL_NONE;
    int stall_phase = 0;

    top_k_sorted_insert_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // queue one item
    task automatic add_item(input t_opcode op, input logic [DIST_W-1:0] d,
                            input logic [ID_W-1:0] id, input logic [FLOOR_W-1:0] fl,
                            input bit drain);
        t_in_item it;
        it.opcode         = op;
        it.distance       = d;
        it.item_id        = id;
        it.floor_position = fl;
        pending_items.push_back(it);
        pending_drain.push_back(drain);
    endtask

    function automatic logic [DIST_W-1:0] pick_distance(input int flavor);
        logic [31:0] r;
        logic [DIST_W-1:0] d;
        r = $urandom;
        case (flavor)
            DIST_FULL:  d = r;
            DIST_TIES:  d = $urandom_range(0, 40);
            DIST_FLOAT: begin
                // nonnegative single precision bit patterns, finite exponents
                d = {1'b0, 8'(0), r[22:0]};
                d[30:23] = 8'($urandom_range(0, 254));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       d = '0;
                    1:       d = '1;
                    2:       d = '1 - $urandom_range(0, 3);
                    default: d = $urandom_range(0, 1000);
                endcase
            end
        endcase
        return d;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        logic [31:0] r;
        r = $urandom;
        return r[ID_W-1:0];
    endfunction

    function automatic logic [FLOOR_W-1:0] pick_floor();
        logic [FLOOR_W-1:0] fl;
        if ($urandom_range(0, 9) < 6)
            fl = '0;
        else
            fl = FLOOR_W'($urandom_range(0, 15));
        return fl;
    endfunction

    // advance the shadow list by one accepted item and queue the results it owes
    task automatic apply_to_shadow_list(input t_in_item it);
        t_out_item res;
        int        pos;
        bit        found;
        if (it.opcode == OP_READOUT) begin
            for (int r = 0; r < LIST_SIZE; r++) begin
                res.accepted       = 1'b1;
                res.slot           = SLOT_W'(r);
                res.entry_distance = shadow_dist[r];
                res.entry_id       = shadow_id[r];
                res.last           = (r == LIST_SIZE - 1);
                owed_results.push_back(res);
            end
            for (int r = 0; r < LIST_SIZE; r++) begin
                shadow_dist[r] = '1;
                shadow_id[r]   = '0;
            end
        end else begin
            // land after the last strictly smaller entry at or above the floor
            pos   = int'(it.floor_position);
            found = 1'b0;
            for (int j = LIST_SIZE - 1; j >= int'(it.floor_position); j--) begin
                if (!found && shadow_dist[j] < it.distance) begin
                    pos   = j + 1;
                    found = 1'b1;
                end
            end
            res.last = 1'b1;
            if (int'(it.floor_position) >= LIST_SIZE || pos >= LIST_SIZE) begin
                // candidate worse than the list, or floor past the end
                res.accepted       = 1'b0;
                res.slot           = SLOT_W'(LIST_SIZE);
                res.entry_distance = it.distance;
                res.entry_id       = it.item_id;
            end else begin
                res.accepted       = 1'b1;
                res.slot           = SLOT_W'(pos);
                res.entry_distance = shadow_dist[LIST_SIZE-1];
                res.entry_id       = shadow_id[LIST_SIZE-1];
                for (int j = LIST_SIZE - 2; j >= pos; j--) begin
                    shadow_dist[j+1] = shadow_dist[j];
                    shadow_id[j+1]   = shadow_id[j];
                end
                shadow_dist[pos] = it.distance;
                shadow_id[pos]   = it.item_id;
            end
            owed_results.push_back(res);
        end
    endtask

    // compare one result item against the oldest owed one
    task automatic compare_result(input t_out_item got);
        t_out_item want;
        if (owed_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result item: acc=%0d slot=%0d dist=%h id=%h last=%0d",
                         got.accepted, got.slot, got.entry_distance, got.entry_id, got.last);
        end else begin
            want = owed_results.pop_front();
            if (got.accepted !== want.accepted || got.slot !== want.slot ||
                got.entry_distance !== want.entry_distance ||
                got.entry_id !== want.entry_id || got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("result item differs at cycle %0d", cycle_count);
                    $display("  expected acc=%0d slot=%0d dist=%h id=%h last=%0d",
                             want.accepted, want.slot, want.entry_distance,
                             want.entry_id, want.last);
                    $display("  actual   acc=%0d slot=%0d dist=%h id=%h last=%0d",
                             got.accepted, got.slot, got.entry_distance,
                             got.entry_id, got.last);
                end
            end
        end
    endtask

    // driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_drain[0] && (i_valid || results_owed != 0 || o_valid)) begin
                    // hold off until every owed result has arrived
                    i_valid <= 1'b0;
                end else begin
                    i_item  <= pending_items.pop_front();
                    void'(pending_drain.pop_front());
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver stall pattern, changing every so often
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode  = $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_phase = $urandom_range(20, 150);
        end
        stall_phase--;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 1) == 0);
            default:     i_stall <= ((stall_phase % 8) < 3);
        endcase
    end

    // monitor: check result items first, then predict from the accepted input item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                compare_result(o_result);
            if (i_valid && !o_stall)
                apply_to_shadow_list(i_item);
            results_owed <= owed_results.size();
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("top_k_sorted_insert_unit: mismatch");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int random_count;
        int n_ins;
        int flavor;
        int episode;
        for (int r = 0; r < LIST_SIZE; r++) begin
            shadow_dist[r] = '1;
            shadow_id[r]   = '0;
        end

        // directed part
        add_item(OP_READOUT, '0, '0, '0, 1'b0);              // empty list after reset
        add_item(OP_INSERT, '0, '1, '0, 1'b0);               // best distance, largest id
        add_item(OP_INSERT, '0, 31'd1, '0, 1'b0);            // lands ahead of its equal
        add_item(OP_INSERT, '1, 31'd2, '0, 1'b0);            // equal to the worst entry
        add_item(OP_INSERT, 32'd5, 31'd3, 4'd15, 1'b0);      // last slot
        add_item(OP_INSERT, 32'd3, 31'd4, 4'd8, 1'b0);       // floor in the middle
        for (int k = 1; k <= 12; k++)
            add_item(OP_INSERT, 32'(k * 10), 31'(k + 100), '0, 1'b0);
        add_item(OP_INSERT, '1, 31'h5555_5555, '0, 1'b0);    // worse than a full list
        add_item(OP_INSERT, '1, 31'h2AAA_AAAA, 4'd15, 1'b0); // worse, top floor
        add_item(OP_INSERT, 32'd1, 31'd200, 4'd15, 1'b0);    // evicts the last slot
        add_item(OP_INSERT, 32'd60, 31'd201, '0, 1'b0);      // ties inside a full list
        add_item(OP_READOUT, '1, '1, '1, 1'b0);
        add_item(OP_READOUT, '0, '0, '0, 1'b1);              // cleared list, after a drain

        // random episodes: fill the list, then read it out
        random_count = 0;
        episode      = 0;
        while (random_count < RANDOM_ITEMS) begin
            n_ins  = $urandom_range(4, 40);
            flavor = $urandom_range(DIST_FULL, DIST_EDGES);
            for (int k = 0; k < n_ins; k++) begin
                if ($urandom_range(0, 29) == 0)
                    add_item(OP_READOUT, pick_distance(DIST_FULL), pick_id(), pick_floor(), 1'b0);
                else
                    add_item(OP_INSERT, pick_distance(flavor), pick_id(), pick_floor(),
                             (k == 0) && (episode % 3 == 1));
                random_count++;
            end
            add_item(OP_READOUT, pick_distance(DIST_FULL), pick_id(), pick_floor(), 1'b0);
            random_count++;
            episode++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid)
            @(posedge i_clk);
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("top_k_sorted_insert_unit: match");
        end else begin
            $display("top_k_sorted_insert_unit: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/tkins_pkg.sv
src/tkins_cell.sv
src/top_k_sorted_insert_unit.sv
test/tb.sv
